@@ sv/scfr_pkg.sv @@
// ----------------------------------------------------------------------------
// scfr_pkg: serial command frame receiver package
// Shared byte type, frame phase codes and checksum helper.
// ----------------------------------------------------------------------------
package scfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] phase_t;
  typedef logic [10:0] check_t;

  localparam byte_t HEADER_BYTE = 8'hFF;

  // frame phase codes
  localparam phase_t PH_HEAD1    = 4'd1;
  localparam phase_t PH_HEAD2    = 4'd2;
  localparam phase_t PH_MODE     = 4'd3;
  localparam phase_t PH_AUX0     = 4'd4;
  localparam phase_t PH_AUX1     = 4'd5;
  localparam phase_t PH_ANGLE    = 4'd6;
  localparam phase_t PH_X0       = 4'd7;
  localparam phase_t PH_X1       = 4'd8;
  localparam phase_t PH_Y0       = 4'd9;
  localparam phase_t PH_Y1       = 4'd10;
  localparam phase_t PH_CHECK_HI = 4'd11;
  localparam phase_t PH_CHECK_LO = 4'd12;

  // |(angle + x0 + x1 + y0 + y1 + 1) - (mode + aux0 + aux1)|, range 0..1276
  function automatic check_t frame_check(
    input byte_t mode_b, input byte_t aux0_b, input byte_t aux1_b,
    input byte_t angle_b, input byte_t x0_b, input byte_t x1_b,
    input byte_t y0_b, input byte_t y1_b
  );
    logic [10:0] plus;
    logic [9:0]  minus;
    logic [11:0] diff;
    plus  = {3'b000, angle_b} + {3'b000, x0_b} + {3'b000, x1_b}
          + {3'b000, y0_b} + {3'b000, y1_b} + 11'd1;
    minus = {2'b00, mode_b} + {2'b00, aux0_b} + {2'b00, aux1_b};
    diff  = {1'b0, plus} - {2'b00, minus};
    if (diff[11]) begin
      frame_check = check_t'(12'd0 - diff);
    end else begin
      frame_check = diff[10:0];
    end
  endfunction

endpackage

@@ sv/serial_command_frame_receiver_top.sv @@
// Path: a byte is taken into the input register, and from there the
// closing check byte loads the result register, so a frame result reaches the
// outputs through two register stages (input register, result register).
// Throughput: one byte per cycle; input stalls only while a result waits.
// Reset: synchronous active-low rst_n clears valids and returns the phase to
// header search; captured bytes are not reset.
// ----------------------------------------------------------------------------
// serial_command_frame_receiver_top: serial command frame receiver
// Finds the two 0xFF header bytes, captures the ten-byte frame behind them and emits
// its fields with a checksum ok flag, then resumes header search.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  scfr_pkg::byte_t in_rx_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_frame_ok,
  output scfr_pkg::byte_t out_mode_value,
  output scfr_pkg::byte_t out_aux_first,
  output scfr_pkg::byte_t out_aux_second,
  output scfr_pkg::byte_t out_angle_value,
  output scfr_pkg::byte_t out_pos_x_first,
  output scfr_pkg::byte_t out_pos_x_second,
  output scfr_pkg::byte_t out_pos_y_first,
  output scfr_pkg::byte_t out_pos_y_second
);
  import scfr_pkg::*;

  logic   in_valid_r;
  byte_t  in_byte_r;
  phase_t phase_r, phase_nxt;
  byte_t  mode_r, aux0_r, aux1_r, angle_r, x0_r, x1_r, y0_r, y1_r, check_hi_r;
  logic   out_valid_r;
  logic   frame_ok_r, frame_ok_nxt;
  logic   blocked;
  logic   proc;
  logic   emit;
  check_t check_val;

  // result register still held by the consumer
  assign blocked  = out_valid_r & out_stall;
  assign proc     = in_valid_r & ~blocked;
  assign in_stall = in_valid_r & blocked;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // checksum and compare for the closing byte
  assign check_val    = frame_check(mode_r, aux0_r, aux1_r, angle_r, x0_r, x1_r, y0_r, y1_r);
  assign frame_ok_nxt = ({5'd0, check_val[10:8]} == check_hi_r) &&
                        (check_val[7:0] == in_byte_r);

  // next phase
  always_comb begin
    emit      = 1'b0;
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEAD2: begin
        phase_nxt = (in_byte_r == HEADER_BYTE) ? PH_MODE : PH_HEAD1;
      end
      PH_MODE, PH_AUX0, PH_AUX1, PH_ANGLE, PH_X0, PH_X1, PH_Y0, PH_Y1,
      PH_CHECK_HI: begin
        phase_nxt = phase_r + 4'd1;
      end
      PH_CHECK_LO: begin
        emit      = 1'b1;
        phase_nxt = PH_HEAD1;
      end
      default: begin
        // first header, and any stray code behaves the same
        phase_nxt = (in_byte_r == HEADER_BYTE) ? PH_HEAD2 : PH_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD1;
    end else if (proc) begin
      phase_r <= phase_nxt;
    end
  end

  // field capture
  always_ff @(posedge clk) begin
    if (proc) begin
      case (phase_r)
        PH_MODE:     mode_r     <= in_byte_r;
        PH_AUX0:     aux0_r     <= in_byte_r;
        PH_AUX1:     aux1_r     <= in_byte_r;
        PH_ANGLE:    angle_r    <= in_byte_r;
        PH_X0:       x0_r       <= in_byte_r;
        PH_X1:       x1_r       <= in_byte_r;
        PH_Y0:       y0_r       <= in_byte_r;
        PH_Y1:       y1_r       <= in_byte_r;
        PH_CHECK_HI: check_hi_r <= in_byte_r;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      frame_ok_r <= frame_ok_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ok     = frame_ok_r;
  // captured bytes stay put until the next frame reaches them
  assign out_mode_value   = mode_r;
  assign out_aux_first    = aux0_r;
  assign out_aux_second   = aux1_r;
  assign out_angle_value  = angle_r;
  assign out_pos_x_first  = x0_r;
  assign out_pos_x_second = x1_r;
  assign out_pos_y_first  = y0_r;
  assign out_pos_y_second = y1_r;

`ifndef NO_ASSERTIONS
  // phase never leaves the frame range
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r >= PH_HEAD1 && phase_r <= PH_CHECK_LO)
    else $error("frame phase out of range");

  // closing byte gives a result and restarts header search
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && phase_r == PH_CHECK_LO) |=> (out_valid_r && phase_r == PH_HEAD1))
    else $error("closing byte did not produce a result");

  // input only held back by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && in_valid_r))
    else $error("input stalled without a waiting result");

  // captured fields frozen while a result waits
  a_fields_hold: assert property (@(posedge clk) disable iff (!rst_n)
    blocked |=> ($stable(mode_r) && $stable(y1_r) && $stable(frame_ok_r)))
    else $error("result fields changed while stalled");
`endif

endmodule
